/* sv/rnrp_pkg.sv */
// Package with shared constants, default contents and conversion helpers for the clock RAM port.
package rnrp_pkg;

    localparam int DEF_RAM_DEPTH = 64;

    // Request opcodes and window offsets.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] OFF_INDEX = 2'd1;
    localparam logic [1:0] OFF_DATA  = 2'd3;

    // Byte addresses inside the clock RAM.
    localparam logic [7:0] ADDR_SECOND   = 8'd0;
    localparam logic [7:0] ADDR_ALM_SEC  = 8'd1;
    localparam logic [7:0] ADDR_MINUTE   = 8'd2;
    localparam logic [7:0] ADDR_ALM_MIN  = 8'd3;
    localparam logic [7:0] ADDR_HOUR     = 8'd4;
    localparam logic [7:0] ADDR_ALM_HOUR = 8'd5;
    localparam logic [7:0] ADDR_WEEKDAY  = 8'd6;
    localparam logic [7:0] ADDR_MONTHDAY = 8'd7;
    localparam logic [7:0] ADDR_MONTH    = 8'd8;
    localparam logic [7:0] ADDR_YEAR     = 8'd9;
    localparam logic [7:0] ADDR_CTRL_A   = 8'd10;
    localparam logic [7:0] ADDR_CTRL_B   = 8'd11;

    // Bit positions in the control bytes.
    localparam int SET_BIT = 7;
    localparam int DM_BIT  = 2;
    localparam int H24_BIT = 1;
    localparam int UIP_BIT = 7;

    localparam logic [7:0] UIP_MASK   = 8'h80;
    localparam logic [7:0] YEAR_BASE  = 8'd68;
    localparam logic [4:0] HOURS_HALF = 5'd12;
    localparam logic [4:0] HOURS_FULL = 5'd24;

    // Power-up contents of the clock RAM; bytes beyond the table read as zero.
    function automatic logic [7:0] default_byte(input logic [7:0] addr);
        logic [7:0] val;
        begin
            case (addr)
                8'd0:    val = 8'd48;
                8'd1:    val = 8'd255;
                8'd2:    val = 8'd21;
                8'd3:    val = 8'd255;
                8'd4:    val = 8'd23;
                8'd5:    val = 8'd255;
                8'd6:    val = 8'd1;
                8'd7:    val = 8'd25;
                8'd8:    val = 8'd3;
                8'd9:    val = 8'd33;
                8'd10:   val = 8'd42;
                8'd11:   val = 8'd14;
                8'd12:   val = 8'd112;
                8'd13:   val = 8'd128;
                8'd22:   val = 8'd17;
                8'd23:   val = 8'd46;
                8'd24:   val = 8'd32;
                8'd25:   val = 8'd1;
                8'd26:   val = 8'd255;
                8'd29:   val = 8'd56;
                8'd30:   val = 8'd135;
                8'd62:   val = 8'd224;
                8'd63:   val = 8'd31;
                default: val = 8'd0;
            endcase
            return val;
        end
    endfunction

    // Binary to packed BCD; the tens digit is truncated to four bits.
    // Division by ten uses the reciprocal 205/2048, exact for all byte values.
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [7:0]  tens;
        logic [7:0]  ones;
        begin
            prod = 16'(v) * 16'd205;
            tens = 8'(prod >> 11);
            ones = v - 8'(tens * 8'd10);
            return {tens[3:0], ones[3:0]};
        end
    endfunction

endpackage

/* sv/rnrp_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
module rnrp_ram
    import rnrp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = DEF_RAM_DEPTH
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/rtc_nvram_register_port_unit.sv */
// Top level of the clock RAM index/data register port.
//
//  Channel   Signals                                   Direction  Carries
//  in        in_valid, in_ready, opcode, port_offset,  input      one bus access request
//            write_data, now_second .. now_year
//  out       out_valid, out_ready, read_data           output     one byte per request
//
// Every request yields exactly one result, which passes from the work stage
// into the output register before it is presented.
// One request is accepted per cycle when the output side keeps up; the clock
// RAM read is issued as the request is accepted and the single write port of
// the RAM is used as the request leaves the work stage.
// Reset clears the index, the time snapshot and the written flags; an entry
// never written reads as its power-up value, so no clearing pass is needed.
// A stalled output holds the request in the work stage and drops in_ready.

module rtc_nvram_register_port_unit
    import rnrp_pkg::*;
#(
    parameter int RAM_DEPTH = DEF_RAM_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [1:0] port_offset,
    input  logic [7:0] write_data,
    input  logic [5:0] now_second,
    input  logic [5:0] now_minute,
    input  logic [4:0] now_hour,
    input  logic [2:0] now_weekday,
    input  logic [4:0] now_monthday,
    input  logic [3:0] now_month,
    input  logic [7:0] now_year,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data
);

    localparam int IDX_W = $clog2(RAM_DEPTH);

    // Selected index and the power-up marks for the clock RAM.
    logic [IDX_W-1:0]     selected_index_reg;
    logic [RAM_DEPTH-1:0] written_reg;

    // Shadow of control byte B; it steers every time read.
    logic [7:0] ctrl_b_reg;

    // Time snapshot.
    logic [5:0] snap_second_reg;
    logic [5:0] snap_minute_reg;
    logic [4:0] snap_hour_reg;
    logic [2:0] snap_weekday_reg;
    logic [4:0] snap_monthday_reg;
    logic [3:0] snap_month_reg;
    logic [7:0] snap_year_reg;

    // Work stage: the accepted request while its RAM read completes.
    logic             s1_valid_reg;
    logic             s1_op_reg;
    logic [1:0]       s1_off_reg;
    logic [7:0]       s1_wdata_reg;
    logic [IDX_W-1:0] s1_index_reg;
    logic             s1_written_reg;
    logic [7:0]       s1_default_reg;
    logic             s1_fwd_reg;
    logic [7:0]       s1_fwd_data_reg;
    logic [5:0]       s1_second_reg;
    logic [5:0]       s1_minute_reg;
    logic [4:0]       s1_hour_reg;
    logic [2:0]       s1_weekday_reg;
    logic [4:0]       s1_monthday_reg;
    logic [3:0]       s1_month_reg;
    logic [7:0]       s1_year_reg;

    // Output register.
    logic       out_valid_reg;
    logic [7:0] read_data_reg;

    logic       in_fire;
    logic       s1_advance;
    logic       index_wr;
    logic       ram_we;
    logic [7:0] ram_wdata;
    logic [7:0] ram_rdata;
    logic       fwd_hit;

    logic [7:0] s1_addr;
    logic [7:0] ram_byte;
    logic       data_rd;
    logic       data_wr;
    logic       time_addr;
    logic       take_now;
    logic       take_snap;
    logic [5:0] cur_second;
    logic [5:0] cur_minute;
    logic [4:0] cur_hour;
    logic [2:0] cur_weekday;
    logic [4:0] cur_monthday;
    logic [3:0] cur_month;
    logic [7:0] cur_year;
    logic [4:0] hour_mod;
    logic [4:0] hour_12;
    logic       hour_pm;
    logic [7:0] bin_val;
    logic [7:0] pm_flag;
    logic       use_conv;
    logic [7:0] toggled;
    logic [7:0] read_data_next;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    // Index writes beyond the RAM are dropped.
    assign index_wr = in_fire && (opcode == OP_WRITE) && (port_offset == OFF_INDEX)
                      && ({1'b0, write_data} < 9'(RAM_DEPTH));

    // A RAM write in the same cycle as a read of the same entry is forwarded.
    assign fwd_hit = in_fire && ram_we && (s1_index_reg == selected_index_reg);

    rnrp_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_index_reg),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (selected_index_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_addr  = 8'(s1_index_reg);
        ram_byte = s1_fwd_reg ? s1_fwd_data_reg
                              : (s1_written_reg ? ram_rdata : s1_default_reg);
        data_rd  = (s1_op_reg == OP_READ) && (s1_off_reg == OFF_DATA);
        data_wr  = (s1_op_reg == OP_WRITE) && (s1_off_reg == OFF_DATA);
        toggled  = ram_byte ^ UIP_MASK;

        time_addr = (s1_addr == ADDR_SECOND) || (s1_addr == ADDR_MINUTE)
                    || (s1_addr == ADDR_HOUR) || (s1_addr == ADDR_WEEKDAY)
                    || (s1_addr == ADDR_MONTHDAY) || (s1_addr == ADDR_MONTH)
                    || (s1_addr == ADDR_YEAR);

        // While SET is low every time read refreshes the snapshot.
        take_now  = data_rd && time_addr && !ctrl_b_reg[SET_BIT];
        take_snap = take_now
                    || (data_wr && (s1_addr == ADDR_CTRL_B) && s1_wdata_reg[SET_BIT]);

        cur_second   = take_now ? s1_second_reg   : snap_second_reg;
        cur_minute   = take_now ? s1_minute_reg   : snap_minute_reg;
        cur_hour     = take_now ? s1_hour_reg     : snap_hour_reg;
        cur_weekday  = take_now ? s1_weekday_reg  : snap_weekday_reg;
        cur_monthday = take_now ? s1_monthday_reg : snap_monthday_reg;
        cur_month    = take_now ? s1_month_reg    : snap_month_reg;
        cur_year     = take_now ? s1_year_reg     : snap_year_reg;

        // 12-hour form: hours 12 and up carry the PM flag, zero shows as 12.
        hour_pm = (cur_hour >= HOURS_HALF);
        if (cur_hour >= HOURS_FULL)
        begin
            hour_mod = cur_hour - HOURS_FULL;
        end
        else if (hour_pm)
        begin
            hour_mod = cur_hour - HOURS_HALF;
        end
        else
        begin
            hour_mod = cur_hour;
        end
        hour_12 = (hour_mod == 5'd0) ? HOURS_HALF : hour_mod;

        pm_flag  = 8'd0;
        use_conv = 1'b1;
        case (s1_addr)
            ADDR_SECOND:   bin_val = 8'(cur_second);
            ADDR_MINUTE:   bin_val = 8'(cur_minute);
            ADDR_HOUR:
            begin
                if (ctrl_b_reg[H24_BIT])
                begin
                    bin_val = 8'(cur_hour);
                end
                else
                begin
                    bin_val = 8'(hour_12);
                    pm_flag = hour_pm ? 8'h80 : 8'h00;
                end
            end
            ADDR_WEEKDAY:  bin_val = 8'(cur_weekday) + 8'd1;
            ADDR_MONTHDAY: bin_val = 8'(cur_monthday);
            ADDR_MONTH:    bin_val = 8'(cur_month) + 8'd1;
            ADDR_YEAR:     bin_val = cur_year - YEAR_BASE;
            ADDR_ALM_SEC, ADDR_ALM_MIN, ADDR_ALM_HOUR:
                           bin_val = ram_byte;
            default:
            begin
                bin_val  = ram_byte;
                use_conv = 1'b0;
            end
        endcase

        if (s1_op_reg == OP_WRITE)
        begin
            read_data_next = 8'd0;
        end
        else if (s1_off_reg == OFF_INDEX)
        begin
            read_data_next = 8'(s1_index_reg);
        end
        else if (s1_off_reg == OFF_DATA)
        begin
            if (use_conv)
            begin
                read_data_next = (ctrl_b_reg[DM_BIT] ? bin_val : to_bcd(bin_val)) | pm_flag;
            end
            else if (s1_addr == ADDR_CTRL_A)
            begin
                read_data_next = toggled;
            end
            else
            begin
                read_data_next = ram_byte;
            end
        end
        else
        begin
            read_data_next = 8'd0;
        end

        // Data writes store the byte; reads of control byte A flip UIP in place.
        ram_we    = s1_advance && (data_wr || (data_rd && (s1_addr == ADDR_CTRL_A)));
        ram_wdata = data_wr ? s1_wdata_reg : toggled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            selected_index_reg <= '0;
            written_reg        <= '0;
            ctrl_b_reg         <= default_byte(ADDR_CTRL_B);
            snap_second_reg    <= '0;
            snap_minute_reg    <= '0;
            snap_hour_reg      <= '0;
            snap_weekday_reg   <= '0;
            snap_monthday_reg  <= '0;
            snap_month_reg     <= '0;
            snap_year_reg      <= '0;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (index_wr)
            begin
                selected_index_reg <= write_data[IDX_W-1:0];
            end
            if (ram_we)
            begin
                written_reg[s1_index_reg] <= 1'b1;
            end
            if (s1_advance && data_wr && (s1_addr == ADDR_CTRL_B))
            begin
                ctrl_b_reg <= s1_wdata_reg;
            end
            if (s1_advance && take_snap)
            begin
                snap_second_reg   <= s1_second_reg;
                snap_minute_reg   <= s1_minute_reg;
                snap_hour_reg     <= s1_hour_reg;
                snap_weekday_reg  <= s1_weekday_reg;
                snap_monthday_reg <= s1_monthday_reg;
                snap_month_reg    <= s1_month_reg;
                snap_year_reg     <= s1_year_reg;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg       <= opcode;
            s1_off_reg      <= port_offset;
            s1_wdata_reg    <= write_data;
            s1_index_reg    <= selected_index_reg;
            s1_written_reg  <= written_reg[selected_index_reg];
            s1_default_reg  <= default_byte(8'(selected_index_reg));
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= ram_wdata;
            s1_second_reg   <= now_second;
            s1_minute_reg   <= now_minute;
            s1_hour_reg     <= now_hour;
            s1_weekday_reg  <= now_weekday;
            s1_monthday_reg <= now_monthday;
            s1_month_reg    <= now_month;
            s1_year_reg     <= now_year;
        end
        if (s1_advance)
        begin
            read_data_reg <= read_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    // A full work stage behind a stalled output must block new requests.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("request accepted while both stages are full");

    // A new result only appears when the work stage hands one over.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_advance))
        else $error("result produced without a request in the work stage");

    // An index outside the RAM leaves the selected index alone.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (opcode == OP_WRITE) && (port_offset == OFF_INDEX)
        && ({1'b0, write_data} >= 9'(RAM_DEPTH)) |=> $stable(selected_index_reg))
        else $error("out-of-range index write changed the index");

    // Forwarded data always belongs to a request that sits in the work stage.
    a_fwd_owner: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit |=> s1_valid_reg && s1_fwd_reg)
        else $error("forwarded byte lost");

endmodule

/* tb/tb_rtc_nvram_register_port_unit.sv */
// Self-checking regression for the clock RAM index/data register port.
module tb_rtc_nvram_register_port_unit
    import rnrp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Wall-clock time that travels with each bus request and feeds the time
    // snapshot.
    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] mins;
        logic [4:0] hour;
        logic [2:0] wday;
        logic [4:0] mday;
        logic [3:0] mon;
        logic [7:0] year;
    } clock_time_t;

    localparam int RAM_BYTES = DEF_RAM_DEPTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 8;

    // Offsets of the window that the block ignores.
    localparam logic [1:0] OFF_INERT_LO = 2'd0;
    localparam logic [1:0] OFF_INERT_HI = 2'd2;

    // Control byte B settings used by the directed tests.
    localparam logic [7:0] CTRL_BCD_12H = 8'h00;
    localparam logic [7:0] CTRL_BIN_24H = 8'((1 << DM_BIT) | (1 << H24_BIT));
    localparam logic [7:0] SET_FLAG = 8'(1 << SET_BIT);
    localparam logic [7:0] PM_FLAG = 8'h80;

    // Time values at the edges of the field ranges, and beyond them.
    localparam clock_time_t T_MIN = '{6'd0, 6'd0, 5'd0, 3'd0, 5'd1, 4'd0, 8'd68};
    localparam clock_time_t T_MAX = '{6'd59, 6'd59, 5'd23, 3'd6, 5'd31, 4'd11, 8'd255};
    localparam clock_time_t T_OVER = '{6'd63, 6'd63, 5'd31, 3'd7, 5'd31, 4'd15, 8'd0};

    // Power-up contents of the clock RAM as seen on the bus.
    localparam logic [7:0] POWER_UP_IMAGE [0:63] = '{
        8'd48, 8'd255, 8'd21, 8'd255, 8'd23, 8'd255, 8'd1, 8'd25,
        8'd3, 8'd33, 8'd42, 8'd14, 8'd112, 8'd128, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd17, 8'd46,
        8'd32, 8'd1, 8'd255, 8'd0, 8'd0, 8'd56, 8'd135, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd224, 8'd31
    };

    // Every input starts at a known value; reset is held from time zero.
    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       opcode = OP_READ;
    logic [1:0] port_offset = OFF_INERT_LO;
    logic [7:0] write_data = 8'd0;
    logic [5:0] now_second = 6'd0;
    logic [5:0] now_minute = 6'd0;
    logic [4:0] now_hour = 5'd0;
    logic [2:0] now_weekday = 3'd0;
    logic [4:0] now_monthday = 5'd1;
    logic [3:0] now_month = 4'd0;
    logic [7:0] now_year = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_data;

    // Shadow of the block's state, kept in step with every accepted request.
    logic [7:0]  nvram_image [0:RAM_BYTES-1];
    logic [7:0]  index_shadow;
    clock_time_t snap_time;

    // Bytes the block still owes, oldest first.
    logic [7:0] pending_read_data [$];

    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_order = 0;
    int hold_left = 0;

    rtc_nvram_register_port_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .port_offset  (port_offset),
        .write_data   (write_data),
        .now_second   (now_second),
        .now_minute   (now_minute),
        .now_hour     (now_hour),
        .now_weekday  (now_weekday),
        .now_monthday (now_monthday),
        .now_month    (now_month),
        .now_year     (now_year),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data)
    );

    // 8 ns clock.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Binary to packed BCD unless control byte B selects binary mode.
    // The tens digit simply falls off the top for values of 160 and up.
    function automatic logic [7:0] clock_digits(input logic [7:0] v);
        int tens;
        int ones;
        tens = v / 10;
        ones = v % 10;
        if (nvram_image[ADDR_CTRL_B][DM_BIT])
            return v;
        return 8'((tens << 4) | ones);
    endfunction

    // Data read at the selected index, including the side effects on the
    // snapshot and on the update-in-progress bit of control byte A.
    function automatic logic [7:0] predict_data_read(input clock_time_t now);
        logic [7:0] ctrl;
        logic [4:0] h;
        logic [7:0] pm;
        ctrl = nvram_image[ADDR_CTRL_B];
        h = 5'd0;
        pm = 8'd0;
        case (index_shadow)
            ADDR_SECOND, ADDR_MINUTE, ADDR_HOUR, ADDR_WEEKDAY,
            ADDR_MONTHDAY, ADDR_MONTH, ADDR_YEAR:
            begin
                // While SET is low every time read sees a fresh snapshot.
                if (!ctrl[SET_BIT])
                    snap_time = now;
            end
            default:
            begin
            end
        endcase
        case (index_shadow)
            ADDR_SECOND:   return clock_digits(8'(snap_time.sec));
            ADDR_MINUTE:   return clock_digits(8'(snap_time.mins));
            ADDR_HOUR:
            begin
                if (ctrl[H24_BIT])
                    return clock_digits(8'(snap_time.hour));
                // 12-hour mode: midnight and noon show as 12, PM flags the
                // afternoon, which includes the out-of-range hours 24 to 31.
                h = snap_time.hour;
                if (h >= HOURS_HALF)
                    pm = PM_FLAG;
                h = h % HOURS_HALF;
                if (h == 5'd0)
                    h = HOURS_HALF;
                return clock_digits(8'(h)) | pm;
            end
            ADDR_WEEKDAY:  return clock_digits(8'(snap_time.wday) + 8'd1);
            ADDR_MONTHDAY: return clock_digits(8'(snap_time.mday));
            ADDR_MONTH:    return clock_digits(8'(snap_time.mon) + 8'd1);
            ADDR_YEAR:     return clock_digits(8'(snap_time.year - YEAR_BASE));
            ADDR_ALM_SEC, ADDR_ALM_MIN, ADDR_ALM_HOUR:
                return clock_digits(nvram_image[index_shadow]);
            ADDR_CTRL_A:
            begin
                nvram_image[ADDR_CTRL_A] = nvram_image[ADDR_CTRL_A] ^ UIP_MASK;
                return nvram_image[ADDR_CTRL_A];
            end
            default:       return nvram_image[index_shadow];
        endcase
    endfunction

    // Applies one accepted request to the shadow state and returns the byte
    // that the block must answer with.
    function automatic logic [7:0] predict_access(input logic op, input logic [1:0] off,
                                                  input logic [7:0] wd, input clock_time_t now);
        logic [7:0] rd;
        rd = 8'd0;
        if (op == OP_WRITE)
        begin
            if (off == OFF_INDEX)
            begin
                // Index values past the end of the RAM leave the index alone.
                if (wd < RAM_BYTES)
                    index_shadow = wd;
            end
            else if (off == OFF_DATA)
            begin
                if (index_shadow == ADDR_CTRL_B && wd[SET_BIT])
                    snap_time = now;
                nvram_image[index_shadow] = wd;
            end
        end
        else
        begin
            if (off == OFF_INDEX)
                rd = index_shadow;
            else if (off == OFF_DATA)
                rd = predict_data_read(now);
        end
        return rd;
    endfunction

    function automatic clock_time_t random_time();
        clock_time_t t;
        if ($urandom_range(7) == 0)
        begin
            // Whole field widths, beyond the calendar ranges.
            t.sec = 6'($urandom);
            t.mins = 6'($urandom);
            t.hour = 5'($urandom);
            t.wday = 3'($urandom);
            t.mday = 5'($urandom);
            t.mon = 4'($urandom);
        end
        else
        begin
            t.sec = 6'($urandom_range(59));
            t.mins = 6'($urandom_range(59));
            t.hour = 5'($urandom_range(23));
            t.wday = 3'($urandom_range(6));
            t.mday = 5'($urandom_range(31, 1));
            t.mon = 4'($urandom_range(11));
        end
        t.year = 8'($urandom);
        return t;
    endfunction

    // Offers one request, with a random number of idle cycles in front of it
    // when the sender idles, and records the expected byte once it is taken.
    // Valid stays high between back-to-back requests.
    task automatic access(input logic op, input logic [1:0] off, input logic [7:0] wd,
                          input clock_time_t now);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        opcode = op;
        port_offset = off;
        write_data = wd;
        now_second = now.sec;
        now_minute = now.mins;
        now_hour = now.hour;
        now_weekday = now.wday;
        now_monthday = now.mday;
        now_month = now.mon;
        now_year = now.year;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_read_data.push_back(predict_access(op, off, wd, now));
    endtask

    // Stops offering requests and waits for every owed byte.
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_read_data.size() != 0)
            @(posedge clk);
    endtask

    // One burst of traffic: mostly an index write followed by a few data
    // accesses at that index, now and then a request with random content.
    task automatic random_burst(output int issued);
        int pick;
        int count;
        logic [7:0] idx;
        logic [1:0] off;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            access(1'($urandom), 2'($urandom), 8'($urandom), random_time());
            issued = 1;
        end
        else
        begin
            // Favor the time and control bytes, but reach the whole RAM and,
            // rarely, indexes that must be ignored.
            pick = $urandom_range(99);
            if (pick < 60)
                idx = 8'($urandom_range(13));
            else if (pick < 92)
                idx = 8'($urandom_range(RAM_BYTES - 1));
            else
                idx = 8'($urandom_range(255, RAM_BYTES));
            access(OP_WRITE, OFF_INDEX, idx, random_time());
            count = $urandom_range(4, 1);
            for (int i = 0; i < count; i++)
            begin
                off = ($urandom_range(9) == 0) ? OFF_INDEX : OFF_DATA;
                access(1'($urandom), off, 8'($urandom), random_time());
            end
            issued = count + 1;
        end
    endtask

    // Power-up values: index zero, the seconds byte in binary mode and the
    // last byte of the table.
    task automatic test_power_up();
        access(OP_READ, OFF_INDEX, 8'hFF, random_time());
        access(OP_READ, OFF_DATA, 8'h00, T_MAX);
        access(OP_WRITE, OFF_INDEX, 8'(RAM_BYTES - 1), random_time());
        access(OP_READ, OFF_DATA, 8'h00, random_time());
    endtask

    // BCD and 12-hour formatting at the field extremes, including the
    // midnight and afternoon cases and values beyond the ranges, then binary
    // 24-hour mode.
    task automatic test_time_formats();
        access(OP_WRITE, OFF_INDEX, ADDR_CTRL_B, random_time());
        access(OP_WRITE, OFF_DATA, CTRL_BCD_12H, random_time());
        access(OP_WRITE, OFF_INDEX, ADDR_HOUR, random_time());
        access(OP_READ, OFF_DATA, 8'h00, T_MIN);
        access(OP_READ, OFF_DATA, 8'h00, T_MAX);
        access(OP_READ, OFF_DATA, 8'h00, T_OVER);
        access(OP_WRITE, OFF_INDEX, ADDR_WEEKDAY, random_time());
        access(OP_READ, OFF_DATA, 8'h00, T_OVER);
        access(OP_WRITE, OFF_INDEX, ADDR_MONTH, random_time());
        access(OP_READ, OFF_DATA, 8'h00, T_OVER);
        access(OP_WRITE, OFF_INDEX, ADDR_YEAR, random_time());
        access(OP_READ, OFF_DATA, 8'h00, T_OVER);
        access(OP_WRITE, OFF_INDEX, ADDR_ALM_HOUR, random_time());
        access(OP_READ, OFF_DATA, 8'h00, random_time());
        access(OP_WRITE, OFF_INDEX, ADDR_CTRL_B, random_time());
        access(OP_WRITE, OFF_DATA, CTRL_BIN_24H, random_time());
        access(OP_WRITE, OFF_INDEX, ADDR_HOUR, random_time());
        access(OP_READ, OFF_DATA, 8'h00, T_MAX);
    endtask

    // Writing SET takes a snapshot and freezes it against later reads.
    task automatic test_snapshot_hold();
        access(OP_WRITE, OFF_INDEX, ADDR_CTRL_B, random_time());
        access(OP_WRITE, OFF_DATA, SET_FLAG, T_MAX);
        access(OP_WRITE, OFF_INDEX, ADDR_SECOND, random_time());
        access(OP_READ, OFF_DATA, 8'h00, T_MIN);
        access(OP_WRITE, OFF_INDEX, ADDR_CTRL_B, random_time());
        access(OP_WRITE, OFF_DATA, CTRL_BIN_24H, T_MIN);
    endtask

    // Each data read of control byte A flips its update-in-progress bit.
    task automatic test_uip_toggle();
        access(OP_WRITE, OFF_INDEX, ADDR_CTRL_A, random_time());
        access(OP_READ, OFF_DATA, 8'h00, random_time());
        access(OP_READ, OFF_DATA, 8'h00, random_time());
    endtask

    // Index writes past the RAM are dropped; the index reads back unchanged.
    task automatic test_index_range();
        access(OP_WRITE, OFF_INDEX, 8'(RAM_BYTES), random_time());
        access(OP_WRITE, OFF_INDEX, 8'hFF, random_time());
        access(OP_READ, OFF_INDEX, 8'h00, random_time());
    endtask

    // The two unused offsets answer zero and change nothing.
    task automatic test_inert_offsets();
        access(OP_READ, OFF_INERT_LO, 8'hFF, random_time());
        access(OP_WRITE, OFF_INERT_HI, 8'hFF, random_time());
        access(OP_READ, OFF_INERT_HI, 8'h00, random_time());
    endtask

    // The receiver holds off while the sender keeps offering, so the block
    // fills and drops in_ready; then the sender waits for the backlog.
    task automatic test_backpressure();
        int issued;
        int total;
        total = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_order = 80;
        while (total < 30)
        begin
            random_burst(issued);
            total += issued;
        end
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int requests, input int send_pct,
                                       input int recv_pct);
        int issued;
        int total;
        total = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (total < requests)
        begin
            random_burst(issued);
            total += issued;
        end
    endtask

    // Receiver: a long hold-off when one is ordered, otherwise random stalls
    // at the current rate, decided at each falling edge.
    always
    begin
        @(negedge clk);
        if (hold_order != 0)
        begin
            hold_left = hold_order;
            hold_order = 0;
        end
        if (hold_left != 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Checker: every byte that leaves the block is matched against the
    // oldest expectation.
    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_read_data.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("read_data %02h arrived with no request pending", read_data);
            end
            else
            begin
                want = pending_read_data.pop_front();
                if (read_data !== want)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("read_data mismatch: expected %02h, got %02h",
                                 want, read_data);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("rtc_nvram_register_port_unit regression: fail");
        $finish;
    end

    // Test sequence: reset, directed checks, back-pressure, then random
    // traffic under three idling patterns.
    initial
    begin
        nvram_image = POWER_UP_IMAGE;
        index_shadow = 8'd0;
        snap_time = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_power_up();
        test_time_formats();
        test_snapshot_hold();
        test_uip_toggle();
        test_index_range();
        test_inert_offsets();
        test_backpressure();
        test_random_traffic(220, 22, 51);
        test_random_traffic(220, 51, 22);
        test_random_traffic(220, 0, 0);

        // Let the last results out and give a stray extra one time to show.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_read_data.size() == 0)
            $display("rtc_nvram_register_port_unit regression: pass");
        else
            $display("rtc_nvram_register_port_unit regression: fail");
        $finish;
    end

endmodule
